@@ sv/drd_pkg.sv @@
// Shared constants, types and helpers for the detection row decoder.
// Every other file of the block imports this package.
package drd_pkg;

  // Class score slots that can win the argmax
  localparam int MAX_CLASSES = 128;
  localparam int BOX_VALUES  = 4;
  localparam int MIN_ROW     = 6;

  // Field widths
  localparam int VALUE_W  = 24;
  localparam int COORD_W  = 16;
  localparam int SCORE_W  = 23;
  localparam int CLASS_W  = 8;
  localparam int ROWLEN_W = 8;
  localparam int THR_W    = 13;
  localparam int SCALE_W  = 24;

  // Box arithmetic: doubled Q12.12 difference times Q8.16 scale, Q.29 product
  localparam int DIFF_W  = VALUE_W + 2;
  localparam int PROD_W  = DIFF_W + SCALE_W + 1;
  localparam int FRAC_SH = 29;
  localparam int QUOT_W  = PROD_W - FRAC_SH;

  // Row queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Configuration port
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 4;

  typedef enum logic [1:0] {
    REG_ROW_LENGTH      = 2'd0,
    REG_SCORE_THRESHOLD = 2'd1,
    REG_SCALE_X         = 2'd2,
    REG_SCALE_Y         = 2'd3
  } reg_idx_t;

  localparam logic [ROWLEN_W-1:0] ROW_LENGTH_RST = ROWLEN_W'(84);
  localparam logic [THR_W-1:0]    THRESHOLD_RST  = THR_W'(1024);
  localparam logic [SCALE_W-1:0]  SCALE_RST      = SCALE_W'(65536);

  localparam logic signed [CLASS_W-1:0] NO_CLASS = {CLASS_W{1'b1}};

  // Live configuration
  typedef struct packed {
    logic [ROWLEN_W-1:0] row_length;
    logic [THR_W-1:0]    score_threshold;
    logic [SCALE_W-1:0]  scale_x;
    logic [SCALE_W-1:0]  scale_y;
  } cfg_t;

  // One finished row that passed the threshold
  typedef struct packed {
    logic signed [VALUE_W-1:0] box_x;
    logic signed [VALUE_W-1:0] box_y;
    logic signed [VALUE_W-1:0] box_w;
    logic signed [VALUE_W-1:0] box_h;
    logic [SCORE_W-1:0]        score;
    logic signed [CLASS_W-1:0] class_id;
  } row_rec_t;

  // Drop FRAC_SH fraction bits rounding toward zero, then clamp to 16 bits
  function automatic logic signed [COORD_W-1:0] trunc_sat16(
    input logic signed [PROD_W-1:0] p
  );
    logic signed [PROD_W-1:0] bias;
    logic signed [PROD_W-1:0] biased;
    logic signed [QUOT_W-1:0] q;
    logic signed [QUOT_W-1:0] sat_hi;
    logic signed [QUOT_W-1:0] sat_lo;
    logic signed [COORD_W-1:0] res;
    bias   = {{(PROD_W-FRAC_SH){1'b0}}, {FRAC_SH{1'b1}}};
    sat_hi = {{(QUOT_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
    sat_lo = {{(QUOT_W-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}};
    biased = p[PROD_W-1] ? (p + bias) : p;
    q      = biased[PROD_W-1:FRAC_SH];
    if (q > sat_hi) begin
      res = sat_hi[COORD_W-1:0];
    end else if (q < sat_lo) begin
      res = sat_lo[COORD_W-1:0];
    end else begin
      res = q[COORD_W-1:0];
    end
    return res;
  endfunction

endpackage

@@ sv/drd_if.sv @@
// Handshake channels of the detection row decoder: tensor values in,
// detections out. Depends on drd_pkg.
interface drd_in_if;
  import drd_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;
  logic                      first_of_frame;
  modport source (output valid, value, first_of_frame, input ready);
  modport sink (input valid, value, first_of_frame, output ready);
endinterface

interface drd_out_if;
  import drd_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] box_left;
  logic signed [COORD_W-1:0] box_top;
  logic signed [COORD_W-1:0] box_width;
  logic signed [COORD_W-1:0] box_height;
  logic [SCORE_W-1:0]        confidence;
  logic signed [CLASS_W-1:0] class_id;
  modport source (output valid, box_left, box_top, box_width, box_height,
                  confidence, class_id, input ready);
  modport sink (input valid, box_left, box_top, box_width, box_height,
                confidence, class_id, output ready);
endinterface

@@ sv/drd_front.sv @@
// Front end: counts row positions, latches the box values, tracks the
// running argmax and pushes rows that pass the threshold. Uses drd_pkg.
module drd_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  drd_pkg::cfg_t                 cfg,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [drd_pkg::VALUE_W-1:0] in_value,
  input  logic                          in_first,
  input  logic                          q_full,
  output logic                          push,
  output drd_pkg::row_rec_t             push_rec
);
  import drd_pkg::*;

  logic [ROWLEN_W-1:0]       pos_r, pos_nxt;
  logic [SCORE_W-1:0]        best_r, best_nxt;
  logic signed [CLASS_W-1:0] cls_r, cls_nxt;
  logic signed [VALUE_W-1:0] box_r [BOX_VALUES];
  logic signed [VALUE_W-1:0] box_nxt [BOX_VALUES];

  logic [ROWLEN_W-1:0]       pos;
  logic [SCORE_W-1:0]        best;
  logic signed [CLASS_W-1:0] cls;
  logic [ROWLEN_W-1:0]       cls_idx;
  logic                      short_row;
  logic                      row_end;
  logic                      accept;

  // Stall only when the row queue cannot take another detection
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // Classify the value and update the row state
  always_comb begin
    pos       = in_first ? '0 : pos_r;
    best      = in_first ? '0 : best_r;
    cls       = in_first ? NO_CLASS : cls_r;
    cls_idx   = pos - ROWLEN_W'(BOX_VALUES);
    short_row = cfg.row_length < ROWLEN_W'(MIN_ROW);
    row_end   = ({1'b0, pos} + 1'b1) >= {1'b0, cfg.row_length};
    best_nxt  = best;
    cls_nxt   = cls;
    box_nxt   = box_r;
    if (!short_row) begin
      if (pos < ROWLEN_W'(BOX_VALUES)) begin
        box_nxt[pos[$clog2(BOX_VALUES)-1:0]] = in_value;
      end else if (cls_idx < ROWLEN_W'(MAX_CLASSES) &&
                   in_value > $signed({1'b0, best})) begin
        best_nxt = in_value[SCORE_W-1:0];
        cls_nxt  = cls_idx[CLASS_W-1:0];
      end
    end
    push = accept && !short_row && row_end &&
           (best_nxt >= SCORE_W'(cfg.score_threshold));
    push_rec.box_x    = box_nxt[0];
    push_rec.box_y    = box_nxt[1];
    push_rec.box_w    = box_nxt[2];
    push_rec.box_h    = box_nxt[3];
    push_rec.score    = best_nxt;
    push_rec.class_id = cls_nxt;
    // Clear the row at its end or while the row length is too short
    if (short_row || row_end) begin
      pos_nxt  = '0;
      best_nxt = '0;
      cls_nxt  = NO_CLASS;
    end else begin
      pos_nxt = pos + 1'b1;
    end
  end

  // Advance row state on each transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      best_r <= '0;
      cls_r  <= NO_CLASS;
      for (int i = 0; i < BOX_VALUES; i++) box_r[i] <= '0;
    end else if (accept) begin
      pos_r  <= pos_nxt;
      best_r <= best_nxt;
      cls_r  <= cls_nxt;
      box_r  <= box_nxt;
    end
  end

endmodule

@@ sv/drd_queue.sv @@
// Short queue of passed rows between the front end and the box arithmetic.
// Flip-flop storage; uses drd_pkg.
module drd_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  drd_pkg::row_rec_t push_rec,
  input  logic              pop,
  output drd_pkg::row_rec_t pop_rec,
  output logic              empty,
  output logic              full
);
  import drd_pkg::*;

  row_rec_t            mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r;
  logic [QPTR_W-1:0]   rd_ptr_r;
  logic [QCNT_W-1:0]   count_r;

  assign empty   = (count_r == '0);
  assign full    = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign pop_rec = mem_r[rd_ptr_r];

  // Hold entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_rec;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      unique case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full) else $error("row pushed into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty) else $error("row popped from empty queue");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QUEUE_DEPTH)) else $error("queue count out of range");

  a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_ptr_r - rd_ptr_r) == count_r[QPTR_W-1:0])
    else $error("queue pointers disagree with count");

endmodule

@@ sv/drd_back.sv @@
// Back end: turns a queued row into a scaled, clamped detection through
// difference, multiply and clamp stages. Uses drd_pkg.
module drd_back (
  input  logic              clk,
  input  logic              rst_n,
  input  drd_pkg::cfg_t     cfg,
  input  logic              q_empty,
  input  drd_pkg::row_rec_t q_rec,
  output logic              pop,
  drd_out_if.source         out_ch
);
  import drd_pkg::*;

  typedef struct packed {
    logic signed [DIFF_W-1:0]  d_left;
    logic signed [DIFF_W-1:0]  d_top;
    logic signed [DIFF_W-1:0]  d_width;
    logic signed [DIFF_W-1:0]  d_height;
    logic [SCORE_W-1:0]        score;
    logic signed [CLASS_W-1:0] class_id;
  } diff_stage_t;

  typedef struct packed {
    logic signed [PROD_W-1:0]  p_left;
    logic signed [PROD_W-1:0]  p_top;
    logic signed [PROD_W-1:0]  p_width;
    logic signed [PROD_W-1:0]  p_height;
    logic [SCORE_W-1:0]        score;
    logic signed [CLASS_W-1:0] class_id;
  } prod_stage_t;

  diff_stage_t a_r, a_nxt;
  prod_stage_t b_r, b_nxt;
  logic        a_v_r, b_v_r, c_v_r;
  logic        a_en, b_en, c_en;

  logic signed [VALUE_W-1:0] c_left_r, c_top_r, c_width_r, c_height_r;
  logic [SCORE_W-1:0]        c_score_r;
  logic signed [CLASS_W-1:0] c_class_r;

  logic signed [SCALE_W:0] sx, sy;

  // Stage enables: a stage loads when it is empty or when the one after it can move
  assign c_en = !c_v_r || out_ch.ready;
  assign b_en = !b_v_r || c_en;
  assign a_en = !a_v_r || b_en;
  assign pop  = !q_empty && a_en;

  // Differences, doubled so every product drops the same fraction bits
  always_comb begin
    a_nxt.d_left   = (DIFF_W'(q_rec.box_x) <<< 1) - DIFF_W'(q_rec.box_w);
    a_nxt.d_top    = (DIFF_W'(q_rec.box_y) <<< 1) - DIFF_W'(q_rec.box_h);
    a_nxt.d_width  = DIFF_W'(q_rec.box_w) <<< 1;
    a_nxt.d_height = DIFF_W'(q_rec.box_h) <<< 1;
    a_nxt.score    = q_rec.score;
    a_nxt.class_id = q_rec.class_id;
  end

  // Products with the scales
  assign sx = $signed({1'b0, cfg.scale_x});
  assign sy = $signed({1'b0, cfg.scale_y});

  always_comb begin
    b_nxt.p_left   = PROD_W'(a_r.d_left * sx);
    b_nxt.p_top    = PROD_W'(a_r.d_top * sy);
    b_nxt.p_width  = PROD_W'(a_r.d_width * sx);
    b_nxt.p_height = PROD_W'(a_r.d_height * sy);
    b_nxt.score    = a_r.score;
    b_nxt.class_id = a_r.class_id;
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
    end else begin
      if (a_en) a_v_r <= !q_empty;
      if (b_en) b_v_r <= a_v_r;
      if (c_en) c_v_r <= b_v_r;
    end
  end

  // Stage payloads
  always_ff @(posedge clk) begin
    if (a_en) a_r <= a_nxt;
    if (b_en) b_r <= b_nxt;
    if (c_en) begin
      c_left_r   <= VALUE_W'(trunc_sat16(b_r.p_left));
      c_top_r    <= VALUE_W'(trunc_sat16(b_r.p_top));
      c_width_r  <= VALUE_W'(trunc_sat16(b_r.p_width));
      c_height_r <= VALUE_W'(trunc_sat16(b_r.p_height));
      c_score_r  <= b_r.score;
      c_class_r  <= b_r.class_id;
    end
  end

  // Drive the result channel from the output register
  assign out_ch.valid      = c_v_r;
  assign out_ch.box_left   = c_left_r[COORD_W-1:0];
  assign out_ch.box_top    = c_top_r[COORD_W-1:0];
  assign out_ch.box_width  = c_width_r[COORD_W-1:0];
  assign out_ch.box_height = c_height_r[COORD_W-1:0];
  assign out_ch.confidence = c_score_r;
  assign out_ch.class_id   = c_class_r;

endmodule

@@ sv/detection_row_decoder.sv @@
// Detection row decoder top level: configuration registers, front end,
// row queue and box arithmetic. Depends on drd_pkg, drd_if and the drd_ modules.
//
// Usage: tensor values arrive on in_ch, one per transfer, in rows of
// row_length values (x, y, w, h, then class scores). first_of_frame drops any
// partial row and starts a new one at that value. For each complete row whose
// best class score reaches score_threshold, one detection leaves on out_ch:
// box scaled to the original frame, confidence and class.
// Throughput: one value per cycle while the row queue is not full. A detection
// shows on out_ch after the row's last value has passed the row queue and the
// difference, multiply and clamp registers. Rows are at least six values long,
// so the back end keeps up whenever out_ch is not stalled.
// When the receiver stalls, up to seven detections wait: four in the row queue
// and three in the pipeline; in_ch.ready drops only when the queue is full.
// Registers are written over the APB-style port while the block is idle: a rule
// for the user that the block does not enforce. Reset (rst_n low, synchronous)
// restores register defaults, clears row state and empties queue and pipeline.
module detection_row_decoder (
  input  logic                              clk,
  input  logic                              rst_n,
  drd_in_if.sink                            in_ch,
  drd_out_if.source                         out_ch,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [drd_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [drd_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [drd_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready
);
  import drd_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t reg_idx;
  logic     cfg_wr;

  logic     push, pop, q_empty, q_full;
  row_rec_t push_rec, pop_rec;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite;

  // Write registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.row_length      <= ROW_LENGTH_RST;
      cfg_r.score_threshold <= THRESHOLD_RST;
      cfg_r.scale_x         <= SCALE_RST;
      cfg_r.scale_y         <= SCALE_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_ROW_LENGTH:      cfg_r.row_length      <= pwdata[ROWLEN_W-1:0];
        REG_SCORE_THRESHOLD: cfg_r.score_threshold <= pwdata[THR_W-1:0];
        REG_SCALE_X:         cfg_r.scale_x         <= pwdata[SCALE_W-1:0];
        REG_SCALE_Y:         cfg_r.scale_y         <= pwdata[SCALE_W-1:0];
        default:             cfg_r                 <= cfg_r;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (reg_idx)
      REG_ROW_LENGTH:      prdata = CFG_DATA_W'(cfg_r.row_length);
      REG_SCORE_THRESHOLD: prdata = CFG_DATA_W'(cfg_r.score_threshold);
      REG_SCALE_X:         prdata = CFG_DATA_W'(cfg_r.scale_x);
      REG_SCALE_Y:         prdata = CFG_DATA_W'(cfg_r.scale_y);
      default:             prdata = '0;
    endcase
  end

  drd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_value (in_ch.value),
    .in_first (in_ch.first_of_frame),
    .q_full   (q_full),
    .push     (push),
    .push_rec (push_rec)
  );

  drd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .pop_rec  (pop_rec),
    .empty    (q_empty),
    .full     (q_full)
  );

  drd_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_empty (q_empty),
    .q_rec   (pop_rec),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule

@@ tb/sv/drd_checker.sv @@
// Detection checker: predicts the detections of the row decoder from the tensor
// value transfers and the register writes it watches, and compares them.
// Depends on drd_pkg and the drd_in_if / drd_out_if channel interfaces.
module drd_detection_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  drd_in_if                              in_mon,
  drd_out_if                             out_mon,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic                           pready,
  input  logic [drd_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [drd_pkg::CFG_DATA_W-1:0] pwdata,
  output int                             fail_count,
  output int                             pending_dets
);
  import drd_pkg::*;

  // Fraction bits dropped: doubled Q12.12 edge times Q8.16 scale, and plain size
  localparam int EDGE_SHIFT = 29;
  localparam int SIZE_SHIFT = 28;

  typedef struct packed {
    logic signed [COORD_W-1:0] box_left;
    logic signed [COORD_W-1:0] box_top;
    logic signed [COORD_W-1:0] box_width;
    logic signed [COORD_W-1:0] box_height;
    logic [SCORE_W-1:0]        confidence;
    logic signed [CLASS_W-1:0] class_id;
  } detection_t;

  // Register copies
  logic [ROWLEN_W-1:0] cfg_row_len;
  logic [THR_W-1:0]    cfg_thr;
  logic [SCALE_W-1:0]  cfg_scale_x;
  logic [SCALE_W-1:0]  cfg_scale_y;

  // Row state
  logic [ROWLEN_W-1:0]       row_pos;
  logic [SCORE_W-1:0]        best_score;
  logic signed [CLASS_W-1:0] best_cls;
  logic signed [VALUE_W-1:0] box_vals [BOX_VALUES];

  detection_t expected_dets [$];
  int         errors = 0;

  assign fail_count = errors;

  function automatic void clear_row();
    row_pos    = '0;
    best_score = '0;
    best_cls   = NO_CLASS;
  endfunction

  function automatic void reset_decoder();
    cfg_row_len = ROW_LENGTH_RST;
    cfg_thr     = THRESHOLD_RST;
    cfg_scale_x = SCALE_RST;
    cfg_scale_y = SCALE_RST;
    clear_row();
    for (int i = 0; i < BOX_VALUES; i++) box_vals[i] = '0;
  endfunction

  // Drop fraction bits toward zero, then clamp to the 16-bit pixel range
  function automatic logic signed [COORD_W-1:0] to_pixels(longint prod, int sh);
    longint q;
    if (prod < 0) q = -((-prod) >>> sh);
    else q = prod >>> sh;
    if (q > 32767) q = 32767;
    else if (q < -32768) q = -32768;
    return COORD_W'(q);
  endfunction

  // Advance the row state by one tensor value; queue a detection at row end
  function automatic void decode_value(logic signed [VALUE_W-1:0] v, logic fof);
    int         cls_idx;
    longint     d;
    detection_t det;
    if (fof) clear_row();
    if (cfg_row_len < MIN_ROW) begin
      clear_row();
      return;
    end
    if (row_pos < BOX_VALUES) begin
      box_vals[row_pos[1:0]] = v;
    end else begin
      cls_idx = int'(row_pos) - BOX_VALUES;
      // classes beyond the argmax range are read but never win
      if (cls_idx < MAX_CLASSES && int'(v) > int'(best_score)) begin
        best_score = v[SCORE_W-1:0];
        best_cls   = CLASS_W'(cls_idx);
      end
    end
    if (int'(row_pos) + 1 < int'(cfg_row_len)) begin
      row_pos = row_pos + 1'b1;
      return;
    end
    if (best_score < cfg_thr) begin
      clear_row();
      return;
    end
    d = 2 * longint'(box_vals[0]) - longint'(box_vals[2]);
    det.box_left   = to_pixels(d * longint'(cfg_scale_x), EDGE_SHIFT);
    d = 2 * longint'(box_vals[1]) - longint'(box_vals[3]);
    det.box_top    = to_pixels(d * longint'(cfg_scale_y), EDGE_SHIFT);
    det.box_width  = to_pixels(longint'(box_vals[2]) * longint'(cfg_scale_x), SIZE_SHIFT);
    det.box_height = to_pixels(longint'(box_vals[3]) * longint'(cfg_scale_y), SIZE_SHIFT);
    det.confidence = best_score;
    det.class_id   = best_cls;
    expected_dets.insert(expected_dets.size(), det);
    clear_row();
  endfunction

  function automatic void write_register(logic [CFG_ADDR_W-1:0] addr,
                                         logic [CFG_DATA_W-1:0] data);
    case (reg_idx_t'(addr[CFG_ADDR_W-1:2]))
      REG_ROW_LENGTH:      cfg_row_len = data[ROWLEN_W-1:0];
      REG_SCORE_THRESHOLD: cfg_thr     = data[THR_W-1:0];
      REG_SCALE_X:         cfg_scale_x = data[SCALE_W-1:0];
      REG_SCALE_Y:         cfg_scale_y = data[SCALE_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic void compare_field(string field, longint want, longint got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endfunction

  // Check result transfers against the oldest prediction, then predict
  always @(posedge clk) begin : monitor
    detection_t want;
    if (!rst_n) begin
      reset_decoder();
      expected_dets.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_dets.size() == 0) begin
          errors++;
          $display("%0t: unexpected detection, expected none, actual %0d %0d %0d %0d %0d %0d",
                   $time, out_mon.box_left, out_mon.box_top, out_mon.box_width,
                   out_mon.box_height, out_mon.confidence, out_mon.class_id);
        end else begin
          want = expected_dets.pop_front();
          compare_field("box_left", want.box_left, out_mon.box_left);
          compare_field("box_top", want.box_top, out_mon.box_top);
          compare_field("box_width", want.box_width, out_mon.box_width);
          compare_field("box_height", want.box_height, out_mon.box_height);
          compare_field("confidence", want.confidence, out_mon.confidence);
          compare_field("class_id", want.class_id, out_mon.class_id);
        end
      end
      if (in_mon.valid && in_mon.ready) decode_value(in_mon.value, in_mon.first_of_frame);
      if (psel && penable && pwrite && pready) write_register(paddr, pwdata);
    end
    pending_dets <= expected_dets.size();
  end

endmodule

@@ tb/sv/tb_detection_row_decoder.sv @@
// Testbench top for the detection row decoder: clock, reset, register writes,
// tensor value stimulus, result-side back-pressure and the final verdict.
// Depends on drd_pkg, drd_if, the decoder RTL and drd_detection_checker.
module tb_detection_row_decoder;
  import drd_pkg::*;

  localparam int STALL_LIMIT   = 4000;
  localparam int DRAIN_SLACK   = 8;
  localparam int RX_HOLD       = 400;
  localparam int RANDOM_ITEMS  = 1000;
  localparam logic signed [VALUE_W-1:0] VALUE_MAX = 24'sh7FFFFF;
  localparam logic signed [VALUE_W-1:0] VALUE_MIN = 24'sh800000;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  logic rx_idle_on  = 1'b1;
  logic rx_hold_req = 1'b0;
  bit   tx_idle_on;
  int   cur_row_len;
  int   random_items;
  int   idle_cycles = 0;
  int   fail_count;
  int   pending_dets;

  drd_in_if  in_ch ();
  drd_out_if out_ch ();

  detection_row_decoder DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  drd_detection_checker detect_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .fail_count   (fail_count),
    .pending_dets (pending_dets)
  );

  always #5 clk = ~clk;

  // Abort when no transfer of any kind happens for too long
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("detection_row_decoder test failed");
      $finish;
    end
  end

  // Result side: random back-pressure, or a long hold-off on request
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        rx_hold_req  <= 1'b0;
        out_ch.ready <= 1'b0;
        repeat (RX_HOLD) @(posedge clk);
      end
      out_ch.ready <= !rx_idle_on || ($urandom_range(99) >= 22);
    end
  end

  task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input int len, input int thr,
                            input logic [SCALE_W-1:0] sx, input logic [SCALE_W-1:0] sy);
    write_reg(REG_ROW_LENGTH, CFG_DATA_W'(len));
    write_reg(REG_SCORE_THRESHOLD, CFG_DATA_W'(thr));
    write_reg(REG_SCALE_X, CFG_DATA_W'(sx));
    write_reg(REG_SCALE_Y, CFG_DATA_W'(sy));
    cur_row_len = len & 255;
  endtask

  // Offer one tensor value, with an occasional gap first; return once transferred
  task automatic send_value(input logic signed [VALUE_W-1:0] v, input logic fof);
    if (tx_idle_on && $urandom_range(99) < 22) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 22);
    end
    in_ch.valid          <= 1'b1;
    in_ch.value          <= v;
    in_ch.first_of_frame <= fof;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (cur_row_len >= MIN_ROW) random_items++;
  endtask

  // Drop valid, wait for every predicted detection, then let the pipeline settle
  task automatic finish_phase();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_dets != 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  function automatic logic signed [VALUE_W-1:0] pick_coord();
    case ($urandom_range(4))
      0: return VALUE_W'($urandom);
      1: return VALUE_W'($urandom_range(0, 640 << 12));
      2: return VALUE_W'(-$urandom_range(0, 64 << 12));
      3: return $urandom_range(1) ? VALUE_MAX : VALUE_MIN;
      default: return '0;
    endcase
  endfunction

  function automatic logic signed [VALUE_W-1:0] pick_score(input int cls);
    // push late classes to the top so the ignored slots would win
    if (cls >= MAX_CLASSES && $urandom_range(1) == 1) return VALUE_MAX;
    case ($urandom_range(4))
      0: return VALUE_W'($urandom);
      1: return VALUE_W'($urandom_range(0, 8191));
      2: return VALUE_W'(-$urandom_range(1, 4096));
      3: return VALUE_W'($urandom_range(0, 3) * 1024);
      default: return $urandom_range(1) ? VALUE_MAX : '0;
    endcase
  endfunction

  function automatic logic [SCALE_W-1:0] pick_scale();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return SCALE_RST;
      3: return SCALE_W'($urandom_range(0, 4 << 16));
      default: return SCALE_W'($urandom);
    endcase
  endfunction

  task automatic random_config();
    int len;
    int thr;
    case ($urandom_range(11))
      0, 1, 2, 3, 4, 5, 6: len = $urandom_range(MIN_ROW, 12);
      7: len = MIN_ROW;
      8: len = $urandom_range(13, 40);
      9: len = $urandom_range(0, MIN_ROW - 1);
      10: len = $urandom_range(7, 10);
      default: len = $urandom_range(1) ? 132 : $urandom_range(133, 255);
    endcase
    case ($urandom_range(4))
      0: thr = 0;
      1: thr = 4096;
      2: thr = 8191;
      default: thr = $urandom_range(0, 8191);
    endcase
    set_config(len, thr, pick_scale(), pick_scale());
  endtask

  // Send rows at the current length; some are cut short and the next one
  // restarts the frame, and a stray frame start lands now and then
  task automatic send_rows(input int n_rows, input bit frame_start);
    int len;
    bit restart;
    if (cur_row_len < MIN_ROW) begin
      repeat (n_rows * 3) send_value(VALUE_W'($urandom), 1'($urandom_range(1)));
      return;
    end
    restart = frame_start;
    for (int r = 0; r < n_rows; r++) begin
      len = cur_row_len;
      if ($urandom_range(99) < 8) len = $urandom_range(1, cur_row_len - 1);
      for (int p = 0; p < len; p++) begin
        send_value(p < BOX_VALUES ? pick_coord() : pick_score(p - BOX_VALUES),
                   (restart && p == 0) || ($urandom_range(99) == 0));
      end
      restart = (len < cur_row_len);
    end
  endtask

  initial begin
    int phase_no;
    rst_n                <= 1'b0;
    psel                 <= 1'b0;
    penable              <= 1'b0;
    pwrite               <= 1'b0;
    paddr                <= '0;
    pwdata               <= '0;
    in_ch.valid          <= 1'b0;
    in_ch.value          <= '0;
    in_ch.first_of_frame <= 1'b0;
    tx_idle_on   = 1'b1;
    cur_row_len  = 84;
    random_items = 0;
    phase_no     = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Field extremes with zero threshold; tied top scores pick the first class
    set_config(MIN_ROW, 0, SCALE_RST, SCALE_RST);
    send_value(VALUE_MAX, 1'b1);
    send_value(VALUE_MIN, 1'b0);
    send_value(VALUE_MIN, 1'b0);
    send_value(VALUE_MAX, 1'b0);
    send_value(24'sd4096, 1'b0);
    send_value(24'sd4096, 1'b0);
    // all scores non-positive: emitted with no class
    repeat (4) send_value('0, 1'b0);
    send_value(-24'sd1, 1'b0);
    send_value(VALUE_MIN, 1'b0);
    // frame restart drops the partial row
    send_value(24'sd100, 1'b0);
    send_value(24'sd200, 1'b0);
    send_value(24'sd300, 1'b0);
    send_value(24'sd4096, 1'b1);
    send_value(24'sd8192, 1'b0);
    send_value(24'sd12288, 1'b0);
    send_value(24'sd16384, 1'b0);
    send_value('0, 1'b0);
    send_value(VALUE_MAX, 1'b0);
    finish_phase();

    // Row length shortened mid-row ends the row at the next value
    set_config(10, 4096, '1, '0);
    send_value(24'sd40960, 1'b1);
    send_value(-24'sd20480, 1'b0);
    send_value(24'sd8192, 1'b0);
    send_value(24'sd4096, 1'b0);
    send_value(24'sd8191, 1'b0);
    send_value(24'sd4095, 1'b0);
    send_value('0, 1'b0);
    finish_phase();
    set_config(MIN_ROW, 4096, '1, '0);
    send_value(24'sd5000, 1'b0);
    finish_phase();

    // Short row length: values are ignored
    set_config(MIN_ROW - 1, 8191, SCALE_RST, SCALE_RST);
    send_value(VALUE_MAX, 1'b0);
    send_value(VALUE_MIN, 1'b1);
    finish_phase();

    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      case (phase_no)
        0: begin
          // Hold the result side off while values keep coming, so the block fills
          set_config(MIN_ROW, 0, SCALE_RST << 1, SCALE_RST >> 1);
          tx_idle_on = 1'b0;
          rx_hold_req <= 1'b1;
          send_rows(14, 1'b1);
          finish_phase();
          tx_idle_on = 1'b1;
        end
        1: begin
          // Stretch with no idling on either side
          set_config($urandom_range(MIN_ROW, 12), $urandom_range(0, 8191),
                     pick_scale(), pick_scale());
          tx_idle_on = 1'b0;
          rx_idle_on <= 1'b0;
          send_rows(25, 1'b1);
          finish_phase();
          tx_idle_on = 1'b1;
          rx_idle_on <= 1'b1;
        end
        2: begin
          // Longest rows: class slots past the argmax range
          set_config(255, 0, pick_scale(), pick_scale());
          send_rows(1, 1'b1);
          finish_phase();
        end
        default: begin
          random_config();
          send_rows(cur_row_len > 40 ? $urandom_range(1, 2) : $urandom_range(3, 10),
                    $urandom_range(99) < 70);
          finish_phase();
        end
      endcase
      phase_no++;
    end

    finish_phase();
    if (fail_count == 0 && pending_dets == 0) begin
      $display("detection_row_decoder test passed");
    end else begin
      $display("detection_row_decoder test failed");
    end
    $finish;
  end

endmodule
